@@ rtl/sem_pkg.sv @@
`default_nettype none

package sem_pkg;

	// image geometry limits
	localparam int MAX_WIDTH    = 4096;
	localparam int MAX_HEIGHT   = 4096;
	localparam int MAX_CHANNELS = 4;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int CH_W    = $clog2(MAX_CHANNELS);
	localparam int DIM_W   = 13;
	localparam int CNT_W   = 3;
	localparam int ADDR_W  = COL_W + CH_W;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;

	localparam int PIX_W  = 8;
	localparam int TAPS_W = 3 * PIX_W;
	localparam int SUM_W  = PIX_W + 2;
	localparam int GRAD_W = SUM_W + 1;
	localparam int SQ_W   = 2 * (GRAD_W - 1);
	localparam int SQSUM_W = SQ_W + 1;
	localparam int NUM_W  = 2 * PIX_W;

	// back end: squares, sum, then one stage per root bit
	localparam int ROOT_W = PIX_W;
	localparam int NSTG   = 2 + ROOT_W;

	// front-to-back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [DIM_W-1:0] DIM_MIN        = 13'd3;
	localparam logic [DIM_W-1:0] WIDTH_MAX      = 13'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_MAX     = 13'(MAX_HEIGHT);
	localparam logic [CNT_W-1:0] CHANNELS_MAX   = 3'(MAX_CHANNELS);
	localparam logic [DIM_W-1:0] WIDTH_RESET    = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET   = 13'd480;
	localparam logic [CNT_W-1:0] CHANNELS_RESET = 3'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_CHANNELS = 2'd2
	} sem_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [CNT_W-1:0] channels;
	} sem_cfg_t;

	// coordinates that travel with an interior result
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic [CH_W-1:0]  channel;
		logic             frame_end;
	} sem_meta_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		sem_meta_t                meta;
	} sem_item_t;

	typedef struct packed {
		logic      valid;
		sem_item_t item;
	} sem_push_t;

	typedef struct packed {
		logic      valid;
		sem_item_t item;
	} sem_head_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		if (v < DIM_MIN) begin
			return DIM_MIN;
		end else if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_chan(input logic [CNT_W-1:0] v);
		if (v == '0) begin
			return 3'd1;
		end else if (v > CHANNELS_MAX) begin
			return CHANNELS_MAX;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/sem_ram.sv @@
`default_nettype none

module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/sem_front.sv @@
`default_nettype none

module sem_front import sem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  sem_cfg_t          cfg,
	input  logic              push,
	output logic              full,
	input  logic [PIX_W-1:0]  sample,
	input  logic              frame_start,
	input  logic [QCNT_W-1:0] q_count,
	output sem_push_t         q_push
);

	typedef struct packed {
		logic [TAPS_W-1:0] left;
		logic [TAPS_W-1:0] mid;
	} sem_win_t;

	logic [DIM_W-1:0] w_eff, h_eff;
	logic [CNT_W-1:0] cc_eff;
	logic accept;

	logic [COL_W-1:0] col_q, base_col, col_next;
	logic [ROW_W-1:0] row_q, base_row, row_next;
	logic [CH_W-1:0]  ch_q, base_ch, ch_next;
	logic [CNT_W-1:0] ch_inc;
	logic [DIM_W-1:0] col_inc, row_inc;
	logic ch_wrap, col_wrap, row_wrap;
	logic [ADDR_W-1:0] rd_addr;

	logic              v_s1, byp_s1, interior_s1;
	logic [PIX_W-1:0]  sample_s1;
	logic [ADDR_W-1:0] addr_s1;
	sem_meta_t         meta_s1;

	logic [PIX_W-1:0] up_rd, md_rd, up_eff, md_eff;
	logic [PIX_W-1:0] fwd_up_q, fwd_md_q;
	sem_win_t         win_q [MAX_CHANNELS];
	logic [TAPS_W-1:0] cur, lft, mid;
	logic [GRAD_W-1:0] gx, gy;

	function automatic logic [SUM_W-1:0] wsum(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c);
		return SUM_W'(a) + (SUM_W'(b) << 1) + SUM_W'(c);
	endfunction

	assign w_eff  = clamp_dim(cfg.width, WIDTH_MAX);
	assign h_eff  = clamp_dim(cfg.height, HEIGHT_MAX);
	assign cc_eff = clamp_chan(cfg.channels);

	// room for the item in flight plus the new one
	assign full   = (q_count + QCNT_W'(v_s1)) >= QCNT_W'(QUEUE_DEPTH);
	assign accept = push && !full;

	// position of the incoming sample and the one after it
	always_comb begin
		base_col = frame_start ? '0 : col_q;
		base_row = frame_start ? '0 : row_q;
		base_ch  = frame_start ? '0 : ch_q;
		ch_inc   = CNT_W'(base_ch) + 3'd1;
		col_inc  = DIM_W'(base_col) + 13'd1;
		row_inc  = DIM_W'(base_row) + 13'd1;
		ch_wrap  = ch_inc >= cc_eff;
		col_wrap = col_inc >= w_eff;
		row_wrap = row_inc >= h_eff;
		ch_next  = ch_wrap ? '0 : ch_inc[CH_W-1:0];
		col_next = base_col;
		row_next = base_row;
		if (ch_wrap) begin
			col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
			if (col_wrap) begin
				row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
			end
		end
		rd_addr = {base_col, base_ch};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ch_q  <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				col_q <= col_next;
				row_q <= row_next;
				ch_q  <= ch_next;
			end
		end
	end

	// classify the sample; flag a line store read right behind a write
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1      <= sample;
			addr_s1        <= rd_addr;
			byp_s1         <= v_s1 && (addr_s1 == rd_addr);
			interior_s1    <= (base_row >= ROW_W'(2)) && (base_col >= COL_W'(2));
			meta_s1.column <= base_col - COL_W'(1);
			meta_s1.row    <= base_row - ROW_W'(1);
			meta_s1.channel   <= base_ch;
			meta_s1.frame_end <= ch_wrap && col_wrap && row_wrap;
		end
		if (v_s1) begin
			fwd_up_q <= md_eff;
			fwd_md_q <= sample_s1;
		end
	end

	// line stores: upper row and middle row per column and channel
	sem_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_upper (
		.clk   (clk),
		.we    (v_s1),
		.waddr (addr_s1),
		.wdata (md_eff),
		.raddr (rd_addr),
		.rdata (up_rd)
	);

	sem_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_middle (
		.clk   (clk),
		.we    (v_s1),
		.waddr (addr_s1),
		.wdata (sample_s1),
		.raddr (rd_addr),
		.rdata (md_rd)
	);

	assign up_eff = byp_s1 ? fwd_up_q : up_rd;
	assign md_eff = byp_s1 ? fwd_md_q : md_rd;

	// 3x3 window: taps are top [7:0], middle [15:8], bottom [23:16]
	always_comb begin
		cur = {sample_s1, md_eff, up_eff};
		lft = win_q[meta_s1.channel].left;
		mid = win_q[meta_s1.channel].mid;
		gx  = GRAD_W'(wsum(cur[7:0], cur[15:8], cur[23:16]))
			- GRAD_W'(wsum(lft[7:0], lft[15:8], lft[23:16]));
		gy  = GRAD_W'(wsum(lft[23:16], mid[23:16], cur[23:16]))
			- GRAD_W'(wsum(lft[7:0], mid[7:0], cur[7:0]));
	end

	// shift the column window of this channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[meta_s1.channel] <= '{left: mid, mid: cur};
		end
	end

	// interior samples go to the back end
	always_comb begin
		q_push.valid   = v_s1 && interior_s1;
		q_push.item.gx = gx;
		q_push.item.gy = gy;
		q_push.item.meta = meta_s1;
	end

endmodule

`default_nettype wire

@@ rtl/sem_queue.sv @@
`default_nettype none

module sem_queue import sem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  sem_push_t         q_push,
	input  logic              deq,
	output sem_head_t         q_head,
	output logic [QCNT_W-1:0] q_count
);

	sem_item_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(q_push.valid) - QCNT_W'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (q_push.valid) begin
			slot_q[wr_ptr_q] <= q_push.item;
		end
	end

	assign q_head.valid = count_q != '0;
	assign q_head.item  = slot_q[rd_ptr_q];
	assign q_count      = count_q;

endmodule

`default_nettype wire

@@ rtl/sem_back.sv @@
`default_nettype none

module sem_back import sem_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  sem_head_t        q_head,
	output logic             deq,
	output logic             empty,
	input  logic             pop,
	output logic [PIX_W-1:0] edge_magnitude,
	output logic [COL_W-1:0] column,
	output logic [ROW_W-1:0] row,
	output logic [CH_W-1:0]  channel,
	output logic             frame_end
);

	// array index is the stage number
	logic              v_s    [1:NSTG];
	sem_meta_t         meta_s [1:NSTG];
	logic [SQ_W-1:0]   sqx_s1, sqy_s1;
	logic [NUM_W-1:0]  num_s  [2:NSTG-1];
	logic              sat_s  [2:NSTG];
	logic [ROOT_W-1:0] root_s [2:NSTG];

	logic signed [2*GRAD_W-1:0] px, py;
	logic [SQSUM_W-1:0] sqsum;
	logic [ROOT_W-1:0]  trial [3:NSTG];
	logic               fits  [3:NSTG];
	logic en;

	// the whole pipe moves unless the finished result is held
	assign en  = !v_s[NSTG] || pop;
	assign deq = en && q_head.valid;

	assign px    = q_head.item.gx * q_head.item.gx;
	assign py    = q_head.item.gy * q_head.item.gy;
	assign sqsum = SQSUM_W'(sqx_s1) + SQSUM_W'(sqy_s1);

	// one root bit per stage, most significant first
	always_comb begin
		for (int k = 3; k <= NSTG; k++) begin
			trial[k] = root_s[k-1] | (ROOT_W'(1) << (NSTG - k));
			fits[k]  = (NUM_W'(trial[k]) * NUM_W'(trial[k])) <= num_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (en) begin
			v_s[1] <= deq;
			for (int k = 2; k <= NSTG; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1    <= px[SQ_W-1:0];
			sqy_s1    <= py[SQ_W-1:0];
			meta_s[1] <= q_head.item.meta;
			for (int k = 2; k <= NSTG; k++) begin
				meta_s[k] <= meta_s[k-1];
			end
			num_s[2]  <= sqsum[NUM_W-1:0];
			sat_s[2]  <= sqsum[SQSUM_W-1:NUM_W] != '0;
			root_s[2] <= '0;
			for (int k = 3; k <= NSTG; k++) begin
				sat_s[k]  <= sat_s[k-1];
				root_s[k] <= fits[k] ? trial[k] : root_s[k-1];
			end
			for (int k = 3; k <= NSTG - 1; k++) begin
				num_s[k] <= num_s[k-1];
			end
		end
	end

	assign empty          = !v_s[NSTG];
	assign edge_magnitude = sat_s[NSTG] ? '1 : root_s[NSTG];
	assign column         = meta_s[NSTG].column;
	assign row            = meta_s[NSTG].row;
	assign channel        = meta_s[NSTG].channel;
	assign frame_end      = meta_s[NSTG].frame_end;

endmodule

`default_nettype wire

@@ rtl/sobel_edge_magnitude.sv @@
`default_nettype none

// Streaming 3x3 Sobel edge magnitude for interleaved 8-bit images. Samples are
// pushed in raster order, channel by channel within a pixel; frame_start on a
// sample restarts the column, row and channel counters. Each interior sample
// yields floor(sqrt(gx^2 + gy^2)) saturated to 255 for the window center, with
// its column, row, channel and a frame_end flag on the last result of the
// image; border samples yield nothing. The block takes one sample per clock
// while full is low, set by the line stores, which are read when a sample is
// taken and written back in the following cycle. A result passes one front
// stage, one queue slot and ten back end stages (squares, sum, eight root
// bits). A held result stalls the back end; the front then fills a four-entry
// queue, and full also counts the sample in flight. Line store contents after
// reset are undefined and need no clearing pass. Configuration writes are
// always ready and must only come while the block is idle.
module sobel_edge_magnitude import sem_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic [PIX_W-1:0]     sample,
	input  logic                 frame_start,
	output logic                 empty,
	input  logic                 pop,
	output logic [PIX_W-1:0]     edge_magnitude,
	output logic [COL_W-1:0]     column,
	output logic [ROW_W-1:0]     row,
	output logic [CH_W-1:0]      channel,
	output logic                 frame_end
);

	sem_cfg_t          cfg_q;
	sem_push_t         q_push;
	sem_head_t         q_head;
	logic [QCNT_W-1:0] q_count;
	logic              deq;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width    <= WIDTH_RESET;
			cfg_q.height   <= HEIGHT_RESET;
			cfg_q.channels <= CHANNELS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:    cfg_q.width    <= cfg_data;
				REG_HEIGHT:   cfg_q.height   <= cfg_data;
				REG_CHANNELS: cfg_q.channels <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	sem_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.sample      (sample),
		.frame_start (frame_start),
		.q_count     (q_count),
		.q_push      (q_push)
	);

	sem_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.deq     (deq),
		.q_head  (q_head),
		.q_count (q_count)
	);

	sem_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_head         (q_head),
		.deq            (deq),
		.empty          (empty),
		.pop            (pop),
		.edge_magnitude (edge_magnitude),
		.column         (column),
		.row            (row),
		.channel        (channel),
		.frame_end      (frame_end)
	);

	// front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.valid && !deq |-> q_count < QCNT_W'(QUEUE_DEPTH))
		else $error("queue overflow");

	// a full queue holds off input
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		q_count == QCNT_W'(QUEUE_DEPTH) |-> full)
		else $error("input open while queue full");

	// back end only takes items that are there
	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> q_head.valid)
		else $error("dequeue from empty queue");

endmodule

`default_nettype wire
